// ----- hdl/sqh_pkg.sv -----
// Package for the square-to-quad homography block: widths, constants and the element type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sqh_pkg;
    localparam int COORD_WIDTH_DEF   = 16;
    localparam int OUT_FRAC_BITS_DEF = 24;
    localparam int COORD_FRAC        = 4;
    localparam int OUT_WIDTH         = 48;
    typedef logic signed [OUT_WIDTH-1:0] t_elem;
endpackage
`default_nettype wire

// ----- hdl/sqh_div.sv -----
// Pipelined unsigned divider on magnitudes, one quotient bit per stage, truncating toward zero.
// Depends on sqh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sqh_div #(
    parameter int NW = 64,
    parameter int DW = 34
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num_mag,
    input  wire logic [DW-1:0] i_den_mag,
    output logic      [NW-1:0] o_quo_mag
);
    import sqh_pkg::*;

    // Each stage holds partial remainder, remaining numerator bits, quotient so far.
    logic [DW:0]   r_rem [NW+1];
    logic [NW-1:0] r_num [NW+1];
    logic [NW-1:0] r_quo [NW+1];
    logic [DW-1:0] r_den [NW+1];

    always_comb begin
        r_rem[0] = '0;
        r_num[0] = i_num_mag;
        r_quo[0] = '0;
        r_den[0] = i_den_mag;
    end

    // One restoring step per register stage.
    for (genvar s = 0; s < NW; s++) begin : g_step
        logic [DW+1:0] n_trial;
        logic [DW:0]   n_shift;
        always_comb begin
            n_shift = {r_rem[s][DW-1:0], r_num[s][NW-1]};
            n_trial = {1'b0, n_shift} - {2'b00, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_trial[DW+1] ? n_shift : n_trial[DW:0];
                r_num[s+1] <= {r_num[s][NW-2:0], 1'b0};
                r_quo[s+1] <= {r_quo[s][NW-2:0], ~n_trial[DW+1]};
                r_den[s+1] <= r_den[s];
            end
        end
    end

    assign o_quo_mag = r_quo[NW];
endmodule
`default_nettype wire

// ----- hdl/square_to_quad_homography.sv -----
// Top level of the square-to-quad homography block: differences, determinants,
// two pipelined dividers and the final perspective terms. Depends on sqh_pkg, sqh_div.
//
//  channel | signals                         | direction
//  input   | i_valid/o_ready, i_x0..i_y2     | corners in
//  output  | o_valid/i_ready, o_m00..o_ok    | matrix out
//
// One item is accepted every cycle while the output is not stalled. The
// dividers produce one quotient bit per stage. The whole pipeline advances
// only when the output register is empty or being taken, so a stall freezes
// every stage together. Reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module square_to_quad_homography #(
    parameter int COORD_WIDTH   = sqh_pkg::COORD_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = sqh_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_x0,
    input  wire logic signed [COORD_WIDTH-1:0] i_y0,
    input  wire logic signed [COORD_WIDTH-1:0] i_x1,
    input  wire logic signed [COORD_WIDTH-1:0] i_y1,
    input  wire logic signed [COORD_WIDTH-1:0] i_x3,
    input  wire logic signed [COORD_WIDTH-1:0] i_y3,
    input  wire logic signed [COORD_WIDTH-1:0] i_x2,
    input  wire logic signed [COORD_WIDTH-1:0] i_y2,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output sqh_pkg::t_elem                     o_m00,
    output sqh_pkg::t_elem                     o_m01,
    output sqh_pkg::t_elem                     o_m02,
    output sqh_pkg::t_elem                     o_m10,
    output sqh_pkg::t_elem                     o_m11,
    output sqh_pkg::t_elem                     o_m12,
    output sqh_pkg::t_elem                     o_m20,
    output sqh_pkg::t_elem                     o_m21,
    output sqh_pkg::t_elem                     o_m22,
    output logic                               o_ok
);
    import sqh_pkg::*;

    localparam int DFW  = COORD_WIDTH + 2;             // differences and cross sums
    localparam int PW   = 2 * DFW + 1;                 // determinants
    localparam int NW   = PW + OUT_FRAC_BITS;          // scaled numerator magnitude
    localparam int DEP  = NW + 1;                      // divider stages + sign stage
    localparam int WW   = NW + COORD_WIDTH + 8;        // wide sums before saturation
    localparam int LAT  = DEP + 6;

    logic en;
    logic r_vld [LAT];

    // Whole pipeline moves when the last stage can empty.
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end
    assign o_valid = r_vld[LAT-1];

    // Stage 1: register the corners.
    logic signed [COORD_WIDTH-1:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2, r_x3, r_y3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0 <= i_x0; r_y0 <= i_y0; r_x1 <= i_x1; r_y1 <= i_y1;
            r_x2 <= i_x2; r_y2 <= i_y2; r_x3 <= i_x3; r_y3 <= i_y3;
        end
    end

    // Stage 2: differences and cross sums.
    logic signed [DFW-1:0] r_sx, r_sy, r_dx1, r_dx2, r_dy1, r_dy2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx  <= DFW'(r_x0) - DFW'(r_x1) + DFW'(r_x2) - DFW'(r_x3);
            r_sy  <= DFW'(r_y0) - DFW'(r_y1) + DFW'(r_y2) - DFW'(r_y3);
            r_dx1 <= DFW'(r_x1) - DFW'(r_x2);
            r_dx2 <= DFW'(r_x3) - DFW'(r_x2);
            r_dy1 <= DFW'(r_y1) - DFW'(r_y2);
            r_dy2 <= DFW'(r_y3) - DFW'(r_y2);
        end
    end

    // Corner data delayed alongside the divider.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
    } t_crn;
    t_crn r_crn [1:LAT-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_crn[1] <= '{r_x0, r_y0, r_x1, r_y1, r_x2, r_y2, r_x3, r_y3};
            for (int k = 2; k < LAT; k++) r_crn[k] <= r_crn[k-1];
        end
    end

    // Stage 3: six products.
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic                 r_aff3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0 <= PW'(r_sx)  * PW'(r_dy2);
            r_p1 <= PW'(r_dx2) * PW'(r_sy);
            r_p2 <= PW'(r_dx1) * PW'(r_sy);
            r_p3 <= PW'(r_sx)  * PW'(r_dy1);
            r_p4 <= PW'(r_dx1) * PW'(r_dy2);
            r_p5 <= PW'(r_dx2) * PW'(r_dy1);
            r_aff3 <= (r_sx == '0) && (r_sy == '0);
        end
    end

    // Stage 4: determinants, magnitudes and signs.
    logic signed [PW-1:0] gn, hn, dn;
    logic [NW-1:0]        r_gmag, r_hmag;
    logic [PW-1:0]        r_dmag;
    logic                 r_gneg, r_hneg, r_dz, r_aff4;
    always_comb begin
        gn = r_p0 - r_p1;
        hn = r_p2 - r_p3;
        dn = r_p4 - r_p5;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gmag <= {(gn[PW-1] ? -gn : gn), OUT_FRAC_BITS'(0)};
            r_hmag <= {(hn[PW-1] ? -hn : hn), OUT_FRAC_BITS'(0)};
            r_dmag <= dn[PW-1] ? -dn : dn;
            r_gneg <= gn[PW-1] ^ dn[PW-1];
            r_hneg <= hn[PW-1] ^ dn[PW-1];
            r_dz   <= (dn == '0);
            r_aff4 <= r_aff3;
        end
    end

    // Dividers for g and h.
    logic [NW-1:0] gq, hq;
    sqh_div #(.NW(NW), .DW(PW)) u_div_g (
        .i_clk(i_clk), .i_en(en), .i_num_mag(r_gmag), .i_den_mag(r_dmag), .o_quo_mag(gq));
    sqh_div #(.NW(NW), .DW(PW)) u_div_h (
        .i_clk(i_clk), .i_en(en), .i_num_mag(r_hmag), .i_den_mag(r_dmag), .o_quo_mag(hq));

    // Flags delayed to match the divider depth.
    logic r_fgn [NW+1], r_fhn [NW+1], r_fdz [NW+1], r_faf [NW+1];
    always_comb begin
        r_fgn[0] = r_gneg; r_fhn[0] = r_hneg; r_fdz[0] = r_dz; r_faf[0] = r_aff4;
    end
    for (genvar s = 0; s < NW; s++) begin : g_flag
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_fgn[s+1] <= r_fgn[s]; r_fhn[s+1] <= r_fhn[s];
                r_fdz[s+1] <= r_fdz[s]; r_faf[s+1] <= r_faf[s];
            end
        end
    end

    function automatic t_elem sat(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] hi, lo;
        begin
            hi = WW'(48'sh7FFF_FFFF_FFFF);
            lo = -hi - WW'(1);
            if (v > hi) sat = 48'sh7FFF_FFFF_FFFF;
            else if (v < lo) sat = 48'sh8000_0000_0000;
            else sat = v[OUT_WIDTH-1:0];
        end
    endfunction

    // Stage after divider: apply sign and saturate g, h.
    t_elem r_g, r_h;
    logic  r_dz5, r_af5;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g   <= sat(r_fgn[NW] ? -WW'(gq) : WW'(gq));
            r_h   <= sat(r_fhn[NW] ? -WW'(hq) : WW'(hq));
            r_dz5 <= r_fdz[NW];
            r_af5 <= r_faf[NW];
        end
    end

    // Products of g and h with corner coordinates.
    localparam int CI = DEP + 3;   // index of corners aligned with r_g
    logic signed [OUT_WIDTH+COORD_WIDTH-1:0] r_gx, r_gy, r_hx, r_hy;
    t_elem r_g6, r_h6;
    logic  r_dz6, r_af6;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gx <= r_g * (OUT_WIDTH+COORD_WIDTH)'(r_crn[CI].x1);
            r_gy <= r_g * (OUT_WIDTH+COORD_WIDTH)'(r_crn[CI].y1);
            r_hx <= r_h * (OUT_WIDTH+COORD_WIDTH)'(r_crn[CI].x3);
            r_hy <= r_h * (OUT_WIDTH+COORD_WIDTH)'(r_crn[CI].y3);
            r_g6 <= r_g; r_h6 <= r_h; r_dz6 <= r_dz5; r_af6 <= r_af5;
        end
    end

    // Final stage: assemble elements.
    t_crn c;
    logic signed [WW-1:0] one;
    assign c   = r_crn[CI+1];
    assign one = WW'(1) <<< OUT_FRAC_BITS;

    function automatic logic signed [WW-1:0] diff(
        input logic signed [COORD_WIDTH-1:0] a, input logic signed [COORD_WIDTH-1:0] b);
        diff = WW'(a) - WW'(b);
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!r_af6 && r_dz6) begin
                o_m00 <= '0; o_m01 <= '0; o_m02 <= '0; o_m10 <= '0; o_m11 <= '0;
                o_m12 <= '0; o_m20 <= '0; o_m21 <= '0; o_m22 <= '0; o_ok <= 1'b0;
            end else begin
                if (r_af6) begin
                    o_m00 <= sat(diff(c.x1, c.x0) <<< (OUT_FRAC_BITS - COORD_FRAC));
                    o_m01 <= sat(diff(c.y1, c.y0) <<< (OUT_FRAC_BITS - COORD_FRAC));
                    o_m10 <= sat(diff(c.x2, c.x1) <<< (OUT_FRAC_BITS - COORD_FRAC));
                    o_m11 <= sat(diff(c.y2, c.y1) <<< (OUT_FRAC_BITS - COORD_FRAC));
                    o_m02 <= '0;
                    o_m12 <= '0;
                end else begin
                    o_m00 <= sat(((diff(c.x1, c.x0) <<< OUT_FRAC_BITS) + WW'(r_gx)) >>> COORD_FRAC);
                    o_m01 <= sat(((diff(c.y1, c.y0) <<< OUT_FRAC_BITS) + WW'(r_gy)) >>> COORD_FRAC);
                    o_m10 <= sat(((diff(c.x3, c.x0) <<< OUT_FRAC_BITS) + WW'(r_hx)) >>> COORD_FRAC);
                    o_m11 <= sat(((diff(c.y3, c.y0) <<< OUT_FRAC_BITS) + WW'(r_hy)) >>> COORD_FRAC);
                    o_m02 <= r_g6;
                    o_m12 <= r_h6;
                end
                o_m20 <= sat(WW'(c.x0) <<< (OUT_FRAC_BITS - COORD_FRAC));
                o_m21 <= sat(WW'(c.y0) <<< (OUT_FRAC_BITS - COORD_FRAC));
                o_m22 <= sat(one);
                o_ok  <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hdl/sqh_checker.sv -----
// Port-level checker for the homography block, bound to the top level.
// Depends on sqh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sqh_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_valid,
    input wire logic           i_ready,
    input wire logic           o_ready,
    input wire logic           o_ok,
    input wire sqh_pkg::t_elem o_m22,
    input wire sqh_pkg::t_elem o_m02
);
    import sqh_pkg::*;

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready) else $error("ready low while output free");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_m22 == '0 && o_m02 == '0)) else $error("failure not zeroed");
    a_ok_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ok) |-> (o_m22 != '0)) else $error("m22 zero on success");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_m22))) else $error("output dropped");
endmodule

bind square_to_quad_homography sqh_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_ready(o_ready), .o_ok(o_ok), .o_m22(o_m22), .o_m02(o_m02));
`default_nettype wire
